// File: sv/lcng_pkg.sv
package lcng_pkg;

   localparam int ID_W          = 10;
   localparam int COORD_W       = 6;
   localparam int CELL_AW       = 2 * COORD_W;
   localparam int LINK_W        = ID_W + 1;
   localparam int CELL_W        = ID_W + 1;
   localparam int POS_W         = 32;
   localparam int DIFF_W        = POS_W + 1;
   localparam int EDGE_W        = 31;
   localparam int COUNT_W       = 7;
   localparam int CSR_IDX_W     = 3;
   localparam int GRID_COLS_MAX = 64;
   localparam int GRID_ROWS_MAX = 64;
   localparam int MAX_NEIGHBOURS = 64;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [1:0] STAT_TRUNC   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_X_ORIGIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ORIGIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS     = 3'd4;

   typedef enum logic [1:0] {
      ACT_CLEAR,
      ACT_INSERT,
      ACT_QUERY_AGENT,
      ACT_QUERY_POINT
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVX,
      ST_DIVY,
      ST_DECIDE,
      ST_INS_RD,
      ST_INS_WR,
      ST_CELL,
      ST_HEAD,
      ST_WALK,
      ST_LINK,
      ST_DONE
   } state_type;

   typedef struct packed {
      action_type         action;
      logic [ID_W-1:0]    agent_id;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] neighbour_id;
      logic            found;
      logic            last;
      logic [1:0]      status;
   } rsp_type;

   typedef struct packed {
      logic               cell_we;
      logic [CELL_AW-1:0] cell_addr;
      logic [CELL_W-1:0]  cell_wdata;
      logic               link_we;
      logic [ID_W-1:0]    link_addr;
      logic [LINK_W-1:0]  link_wdata;
   } store_req_type;

endpackage

// File: sv/lcng_div.sv
module lcng_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             div_start,
   input  logic [lcng_pkg::DIFF_W-1:0]      dividend,
   input  logic [lcng_pkg::EDGE_W-1:0]      divisor,
   output logic                             div_done,
   output logic [lcng_pkg::DIFF_W-1:0]      quotient
);
   import lcng_pkg::*;

   localparam int CNT_W = $clog2(DIFF_W);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [EDGE_W-1:0]   rem_ff, rem_in;
   logic [DIFF_W-1:0]   quo_ff, quo_in;
   logic [EDGE_W-1:0]   div_ff, div_in;
   logic [EDGE_W:0]     trial;
   logic                ge;

   // One restoring step per cycle: the dividend shifts out of the quotient register.
   always_comb begin
      trial   = {rem_ff, quo_ff[DIFF_W-1]};
      ge      = trial >= {1'b0, div_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (div_start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (run_ff) begin
         rem_in = ge ? EDGE_W'(trial - {1'b0, div_ff}) : trial[EDGE_W-1:0];
         quo_in = {quo_ff[DIFF_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIFF_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/lcng_store.sv
module lcng_store (
   input  logic                          clock,
   input  lcng_pkg::store_req_type       store_req,
   output logic [lcng_pkg::CELL_W-1:0]   cell_rdata,
   output logic [lcng_pkg::LINK_W-1:0]   link_rdata
);
   import lcng_pkg::*;

   // Cell entry: occupied flag on top of the list head id.
   logic [CELL_W-1:0] cell_mem [2**CELL_AW];
   logic [LINK_W-1:0] link_mem [2**ID_W];
   logic [CELL_W-1:0] cell_rd_ff;
   logic [LINK_W-1:0] link_rd_ff;

   always_ff @(posedge clock) begin
      if (store_req.cell_we) begin
         cell_mem[store_req.cell_addr] <= store_req.cell_wdata;
      end
      cell_rd_ff <= cell_mem[store_req.cell_addr];
   end

   always_ff @(posedge clock) begin
      if (store_req.link_we) begin
         link_mem[store_req.link_addr] <= store_req.link_wdata;
      end
      link_rd_ff <= link_mem[store_req.link_addr];
   end

   assign cell_rdata = cell_rd_ff;
   assign link_rdata = link_rd_ff;

endmodule

// File: sv/linked_cell_neighbour_grid_top.sv
// Clear sweeps all 4096 cells; after reset the same sweep runs with busy high.
// Insert, query and out-of-grid items first run two divisions, x then y, in the
// shared divider. Queries then visit each cell in range and each agent in its list.
// One item at a time; busy is high from acceptance until the cycle of the last result.
// Results are one-cycle strobes on rsp_valid; the receiver cannot stall them.
// Reset is synchronous, active high, and restores the register defaults.
module linked_cell_neighbour_grid_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  lcng_pkg::req_type                 req,
   output logic                              rsp_valid,
   output lcng_pkg::rsp_type                 rsp,
   input  logic                              csr_we,
   input  logic [lcng_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);
   import lcng_pkg::*;

   state_type               state_ff, state_in;
   req_type                 item_ff, item_in;
   logic signed [31:0]      xorg_ff, yorg_ff;
   logic [EDGE_W-1:0]       edge_ff;
   logic [6:0]              cols_ff, rows_ff;
   logic [DIFF_W-1:0]       dy_ff, dy_in, qx_ff, qx_in, qy_ff, qy_in;
   logic                    negx_ff, negx_in;
   logic [1:0]              di_ff, di_in, dj_ff, dj_in;
   logic [ID_W-1:0]         p_ff, p_in, steps_ff, steps_in, pend_id_ff, pend_id_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    trunc_ff, trunc_in, pend_ff, pend_in;
   logic [CELL_AW-1:0]      clr_ff, clr_in;
   logic                    clr_ack_ff, clr_ack_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    accept;
   logic [DIFF_W-1:0]       dx_new, dy_new, div_dividend;
   logic                    div_start, div_done;
   logic [DIFF_W-1:0]       quotient;
   logic [EDGE_W-1:0]       edge_eff;
   logic [7:0]              cols_eff, rows_eff, ni, nj;
   logic                    on_grid, cell_ok, last_cell, skip_self;
   store_req_type           store_req;
   logic [CELL_W-1:0]       cell_rdata;
   logic [LINK_W-1:0]       link_rdata;

   lcng_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_start(div_start),
      .dividend (div_dividend),
      .divisor  (edge_eff),
      .div_done (div_done),
      .quotient (quotient)
   );

   lcng_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .cell_rdata(cell_rdata),
      .link_rdata(link_rdata)
   );

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;
   assign dx_new = DIFF_W'(signed'(req.pos_x)) - DIFF_W'(signed'(xorg_ff));
   assign dy_new = DIFF_W'(signed'(req.pos_y)) - DIFF_W'(signed'(yorg_ff));

   always_comb begin
      edge_eff = (edge_ff == '0) ? EDGE_W'(1) : edge_ff;
      cols_eff = (cols_ff == '0) ? 8'd1 :
                 (cols_ff > 7'(GRID_COLS_MAX)) ? 8'(GRID_COLS_MAX) : {1'b0, cols_ff};
      rows_eff = (rows_ff == '0) ? 8'd1 :
                 (rows_ff > 7'(GRID_ROWS_MAX)) ? 8'(GRID_ROWS_MAX) : {1'b0, rows_ff};
      // A negative offset always lands left of or below the grid.
      on_grid  = !negx_ff && !dy_ff[DIFF_W-1] &&
                 (qx_ff < DIFF_W'(cols_eff)) && (qy_ff < DIFF_W'(rows_eff));
      ni       = {2'b00, qx_ff[COORD_W-1:0]} + {6'b0, di_ff} - 8'd1;
      nj       = {2'b00, qy_ff[COORD_W-1:0]} + {6'b0, dj_ff} - 8'd1;
      cell_ok  = !ni[7] && !nj[7] && (ni < cols_eff) && (nj < rows_eff);
      last_cell = (di_ff == 2'd2) && (dj_ff == 2'd2);
      skip_self = (item_ff.action == ACT_QUERY_AGENT) && (p_ff == item_ff.agent_id);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = (req.action == ACT_CLEAR) ? ST_CLEAR : ST_DIVX;
         end
         ST_DIVX: begin
            if (div_done) state_in = ST_DIVY;
         end
         ST_DIVY: begin
            if (div_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!on_grid) state_in = ST_IDLE;
            else if (item_ff.action == ACT_INSERT) state_in = ST_INS_RD;
            else state_in = ST_CELL;
         end
         ST_INS_RD: state_in = ST_INS_WR;
         ST_INS_WR: state_in = ST_IDLE;
         ST_CELL: begin
            if (cell_ok) state_in = ST_HEAD;
            else if (last_cell) state_in = ST_DONE;
         end
         ST_HEAD: begin
            if (cell_rdata[CELL_W-1]) state_in = ST_WALK;
            else if (last_cell) state_in = ST_DONE;
            else state_in = ST_CELL;
         end
         ST_WALK: begin
            if (!skip_self && count_ff >= COUNT_W'(MAX_NEIGHBOURS)) state_in = ST_DONE;
            else state_in = ST_LINK;
         end
         ST_LINK: begin
            if (link_rdata[LINK_W-1] || steps_ff == '1) begin
               state_in = last_cell ? ST_DONE : ST_CELL;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      item_in      = item_ff;
      dy_in        = dy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      negx_in      = negx_ff;
      di_in        = di_ff;
      dj_in        = dj_ff;
      p_in         = p_ff;
      steps_in     = steps_ff;
      count_in     = count_ff;
      trunc_in     = trunc_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      clr_in       = clr_ff;
      clr_ack_in   = clr_ack_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{neighbour_id: '0, found: 1'b0, last: 1'b1, status: STAT_OK};
      div_start    = 1'b0;
      div_dividend = dy_ff[DIFF_W-1] ? '0 : dy_ff;
      store_req    = '{cell_we: 1'b0, cell_addr: {nj[COORD_W-1:0], ni[COORD_W-1:0]},
                       cell_wdata: '0, link_we: 1'b0, link_addr: p_ff, link_wdata: '0};

      unique case (state_ff)
         ST_CLEAR: begin
            store_req.cell_we   = 1'b1;
            store_req.cell_addr = clr_ff;
            clr_in              = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               rsp_valid_in = clr_ack_ff;
               clr_ack_in   = 1'b0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in  = req;
               dy_in    = dy_new;
               negx_in  = dx_new[DIFF_W-1];
               di_in    = '0;
               dj_in    = '0;
               count_in = '0;
               trunc_in = 1'b0;
               pend_in  = 1'b0;
               if (req.action == ACT_CLEAR) begin
                  clr_in     = '0;
                  clr_ack_in = 1'b1;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = dx_new[DIFF_W-1] ? '0 : dx_new;
               end
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               qx_in     = quotient;
               div_start = 1'b1;
            end
         end
         ST_DIVY: begin
            if (div_done) qy_in = quotient;
         end
         ST_DECIDE: begin
            if (!on_grid) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_OUTSIDE;
            end
         end
         ST_INS_RD: begin
            store_req.cell_addr = {qy_ff[COORD_W-1:0], qx_ff[COORD_W-1:0]};
         end
         ST_INS_WR: begin
            store_req.cell_addr  = {qy_ff[COORD_W-1:0], qx_ff[COORD_W-1:0]};
            store_req.cell_we    = 1'b1;
            store_req.cell_wdata = {1'b1, item_ff.agent_id};
            store_req.link_we    = 1'b1;
            store_req.link_addr  = item_ff.agent_id;
            store_req.link_wdata = cell_rdata[CELL_W-1] ? {1'b0, cell_rdata[ID_W-1:0]}
                                                         : {1'b1, {ID_W{1'b0}}};
            rsp_valid_in = 1'b1;
         end
         ST_CELL: begin
            if (!cell_ok) begin
               di_in = (dj_ff == 2'd2) ? di_ff + 2'd1 : di_ff;
               dj_in = (dj_ff == 2'd2) ? 2'd0 : dj_ff + 2'd1;
            end
         end
         ST_HEAD: begin
            p_in     = cell_rdata[ID_W-1:0];
            steps_in = '0;
            if (!cell_rdata[CELL_W-1]) begin
               di_in = (dj_ff == 2'd2) ? di_ff + 2'd1 : di_ff;
               dj_in = (dj_ff == 2'd2) ? 2'd0 : dj_ff + 2'd1;
            end
         end
         ST_WALK: begin
            // The held agent goes out once the next one is known, so the
            // final one can still be marked last.
            if (!skip_self) begin
               if (count_ff >= COUNT_W'(MAX_NEIGHBOURS)) begin
                  trunc_in = 1'b1;
               end else begin
                  count_in   = count_ff + 1'b1;
                  pend_in    = 1'b1;
                  pend_id_in = p_ff;
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{neighbour_id: pend_id_ff, found: 1'b1, last: 1'b0,
                                      status: STAT_OK};
                  end
               end
            end
         end
         ST_LINK: begin
            if (link_rdata[LINK_W-1] || steps_ff == '1) begin
               di_in = (dj_ff == 2'd2) ? di_ff + 2'd1 : di_ff;
               dj_in = (dj_ff == 2'd2) ? 2'd0 : dj_ff + 2'd1;
            end else begin
               p_in     = link_rdata[ID_W-1:0];
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (pend_ff) begin
               rsp_in = '{neighbour_id: pend_id_ff, found: 1'b1, last: 1'b1,
                          status: trunc_ff ? STAT_TRUNC : STAT_OK};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_ack_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         xorg_ff      <= '0;
         yorg_ff      <= '0;
         edge_ff      <= EDGE_W'(256);
         cols_ff      <= 7'd64;
         rows_ff      <= 7'd64;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_ack_ff   <= clr_ack_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_X_ORIGIN: xorg_ff <= csr_wdata;
               CSR_Y_ORIGIN: yorg_ff <= csr_wdata;
               CSR_EDGE:     edge_ff <= csr_wdata[EDGE_W-1:0];
               CSR_COLS:     cols_ff <= csr_wdata[6:0];
               CSR_ROWS:     rows_ff <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
      item_ff    <= item_in;
      dy_ff      <= dy_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      negx_ff    <= negx_in;
      di_ff      <= di_in;
      dj_ff      <= dj_in;
      p_ff       <= p_in;
      steps_ff   <= steps_in;
      count_ff   <= count_in;
      trunc_ff   <= trunc_in;
      pend_ff    <= pend_in;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: tb/sv/tb_linked_cell_neighbour_grid_top.sv
module tb_linked_cell_neighbour_grid_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lcng_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req = '0;
   logic                 rsp_valid;
   rsp_type              rsp;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_X_ORIGIN;
   logic [31:0]          csr_wdata = '0;

   // Shadow copy of the grid state and registers.
   longint      x_org, y_org;
   logic [30:0] edge_len;
   logic [6:0]  cols_reg, rows_reg;
   bit          occupied [4096];
   logic [9:0]  head_id [4096];
   logic [10:0] next_id [1024];

   rsp_type pending_rsp[$];
   row_type directed[$];
   int      mismatches = 0;
   int      idle_cycles = 0;

   linked_cell_neighbour_grid_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint floor_div(longint d, longint e);
      if (d >= 0) return d / e;
      return -((-d + e - 1) / e);
   endfunction

   function automatic int eff_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > GRID_COLS_MAX) return GRID_COLS_MAX;
      return cols_reg;
   endfunction

   function automatic int eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > GRID_ROWS_MAX) return GRID_ROWS_MAX;
      return rows_reg;
   endfunction

   function automatic longint eff_edge();
      return (edge_len == 0) ? 1 : longint'(edge_len);
   endfunction

   function automatic rsp_type mk_rsp(int id, bit fnd, bit lst, logic [1:0] st);
      rsp_type r;
      r.neighbour_id = 10'(id);
      r.found = fnd;
      r.last = lst;
      r.status = st;
      return r;
   endfunction

   // Works out the results of one item and updates the shadow grid.
   task automatic search_grid(input req_type r, ref rsp_type res[$]);
      longint cx, cy, ci, cj;
      int     n, c;
      bit     trunc;
      logic [9:0] p;
      res.delete();
      if (r.action == ACT_CLEAR) begin
         foreach (occupied[k]) occupied[k] = 0;
         res = {res, mk_rsp(0, 0, 1, STAT_OK)};
         return;
      end
      cx = floor_div(longint'(r.pos_x) - x_org, eff_edge());
      cy = floor_div(longint'(r.pos_y) - y_org, eff_edge());
      if (cx < 0 || cx >= eff_cols() || cy < 0 || cy >= eff_rows()) begin
         res = {res, mk_rsp(0, 0, 1, STAT_OUTSIDE)};
         return;
      end
      if (r.action == ACT_INSERT) begin
         c = int'(cy) * GRID_COLS_MAX + int'(cx);
         next_id[r.agent_id] = occupied[c] ? {1'b0, head_id[c]} : 11'h400;
         head_id[c] = r.agent_id;
         occupied[c] = 1;
         res = {res, mk_rsp(0, 0, 1, STAT_OK)};
         return;
      end
      n = 0;
      trunc = 0;
      for (ci = cx - 1; ci <= cx + 1 && !trunc; ci++) begin
         for (cj = cy - 1; cj <= cy + 1 && !trunc; cj++) begin
            if (ci < 0 || ci >= eff_cols() || cj < 0 || cj >= eff_rows()) continue;
            c = int'(cj) * GRID_COLS_MAX + int'(ci);
            if (!occupied[c]) continue;
            p = head_id[c];
            for (int steps = 0; steps < 1024; steps++) begin
               if (!(r.action == ACT_QUERY_AGENT && p == r.agent_id)) begin
                  if (n >= MAX_NEIGHBOURS) begin
                     trunc = 1;
                     break;
                  end
                  res = {res, mk_rsp(p, 1, 0, STAT_OK)};
                  n++;
               end
               if (next_id[p][10]) break;
               p = next_id[p][9:0];
            end
         end
      end
      if (n == 0) begin
         res = {res, mk_rsp(0, 0, 1, STAT_OK)};
         return;
      end
      res[n-1].last = 1;
      if (trunc) res[n-1].status = STAT_TRUNC;
   endtask

   // Called at a rising edge; returns at the edge where the item was taken.
   task automatic send_item(input req_type r, input bit typed, input rsp_type want);
      rsp_type res[$];
      req <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      search_grid(r, res);
      if (typed) pending_rsp = {pending_rsp, want};
      else foreach (res[k]) pending_rsp = {pending_rsp, res[k]};
   endtask

   task automatic idle_gap();
      int roll, gap;
      roll = $urandom_range(0, 99);
      if (roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(20, 80);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_X_ORIGIN: x_org = longint'(signed'(data));
         CSR_Y_ORIGIN: y_org = longint'(signed'(data));
         CSR_EDGE:     edge_len = data[30:0];
         CSR_COLS:     cols_reg = data[6:0];
         CSR_ROWS:     rows_reg = data[6:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(input logic [31:0] xo, input logic [31:0] yo,
                           input logic [31:0] e, input logic [31:0] nc,
                           input logic [31:0] nr);
      write_reg(CSR_X_ORIGIN, xo);
      write_reg(CSR_Y_ORIGIN, yo);
      write_reg(CSR_EDGE, e);
      write_reg(CSR_COLS, nc);
      write_reg(CSR_ROWS, nr);
   endtask

   function automatic logic [31:0] coord(longint org, int cells);
      longint v;
      v = org + longint'($urandom_range(0, cells + 1) - 1) * eff_edge()
          + longint'($urandom_range(0, 32'(eff_edge() - 1)));
      return v[31:0];
   endfunction

   function automatic req_type random_item(int insert_pct);
      req_type r;
      int roll;
      roll = $urandom_range(0, 99);
      r.agent_id = ($urandom_range(0, 1)) ? 10'($urandom_range(0, 1023))
                                           : 10'($urandom_range(0, 23));
      r.pos_x = coord(x_org, eff_cols());
      r.pos_y = coord(y_org, eff_rows());
      if (roll < 3) r.action = ACT_CLEAR;
      else if (roll < 3 + insert_pct) r.action = ACT_INSERT;
      else if (roll < 3 + insert_pct + (97 - insert_pct) / 2) r.action = ACT_QUERY_AGENT;
      else r.action = ACT_QUERY_POINT;
      // A few items carry arbitrary positions, mostly off the grid.
      if ($urandom_range(0, 9) == 0) begin
         r.pos_x = $urandom;
         r.pos_y = $urandom;
      end
      return r;
   endfunction

   task automatic add_row(input action_type a, input int id, input int px, input int py,
                          input bit typed, input rsp_type want);
      row_type w;
      w.item.action = a;
      w.item.agent_id = 10'(id);
      w.item.pos_x = px;
      w.item.pos_y = py;
      w.typed = typed;
      w.want = want;
      directed = {directed, w};
   endtask

   task automatic random_phase(input int count, input int insert_pct);
      rsp_type none;
      req_type r;
      none = '0;
      r = '0;
      r.action = ACT_CLEAR;
      send_item(r, 0, none);
      for (int k = 0; k < count; k++) begin
         idle_gap();
         send_item(random_item(insert_pct), 0, none);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result id=%0d found=%0b last=%0b status=%0d",
                     $time, rsp.neighbour_id, rsp.found, rsp.last, rsp.status);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.neighbour_id !== want.neighbour_id || rsp.found !== want.found ||
                rsp.last !== want.last || rsp.status !== want.status) begin
               $display("%0t: expected id/found/last/status %0d/%0b/%0b/%0d, got %0d/%0b/%0b/%0d",
                        $time, want.neighbour_id, want.found, want.last, want.status,
                        rsp.neighbour_id, rsp.found, rsp.last, rsp.status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("linked_cell_neighbour_grid_top regression: fail");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      x_org = 0;
      y_org = 0;
      edge_len = 256;
      cols_reg = 64;
      rows_reg = 64;
      foreach (occupied[k]) occupied[k] = 0;

      add_row(ACT_CLEAR, 0, 0, 0, 1, mk_rsp(0, 0, 1, STAT_OK));
      add_row(ACT_QUERY_AGENT, 7, 0, 0, 1, mk_rsp(0, 0, 1, STAT_OK));
      add_row(ACT_INSERT, 7, 0, 0, 1, mk_rsp(0, 0, 1, STAT_OK));
      add_row(ACT_QUERY_POINT, 7, 0, 0, 1, mk_rsp(7, 1, 1, STAT_OK));
      add_row(ACT_QUERY_AGENT, 7, 0, 0, 1, mk_rsp(0, 0, 1, STAT_OK));
      add_row(ACT_INSERT, 1023, 64*256-1, 64*256-1, 1, mk_rsp(0, 0, 1, STAT_OK));
      add_row(ACT_QUERY_POINT, 0, 63*256, 63*256, 1, mk_rsp(1023, 1, 1, STAT_OK));
      add_row(ACT_INSERT, 5, -1, 0, 1, mk_rsp(0, 0, 1, STAT_OUTSIDE));
      add_row(ACT_INSERT, 5, 0, 64*256, 1, mk_rsp(0, 0, 1, STAT_OUTSIDE));
      add_row(ACT_QUERY_POINT, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1,
              mk_rsp(0, 0, 1, STAT_OUTSIDE));
      add_row(ACT_QUERY_AGENT, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 1,
              mk_rsp(0, 0, 1, STAT_OUTSIDE));
      add_row(ACT_INSERT, 3, 256, 256, 0, none);
      add_row(ACT_INSERT, 5, 0, 300, 0, none);
      add_row(ACT_INSERT, 0, 511, 100, 0, none);
      add_row(ACT_INSERT, 3, 256, 256, 0, none);
      add_row(ACT_QUERY_POINT, 0, 256, 256, 0, none);
      add_row(ACT_QUERY_AGENT, 3, 256, 256, 0, none);
      add_row(ACT_QUERY_AGENT, 5, 600, 600, 0, none);
      add_row(ACT_QUERY_POINT, 0, 63*256, 0, 0, none);
      add_row(ACT_CLEAR, 0, 0, 0, 1, mk_rsp(0, 0, 1, STAT_OK));
      add_row(ACT_QUERY_POINT, 0, 256, 256, 1, mk_rsp(0, 0, 1, STAT_OK));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         send_item(directed[k].item, directed[k].typed, directed[k].want);
         idle_gap();
      end

      // Small dense grid so that lists grow long and queries truncate.
      set_grid(-32'sd1000, 32'sd500, 100, 3, 3);
      random_phase(110, 65);
      // Largest cells from the most negative origin, one cell.
      set_grid(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1);
      random_phase(40, 45);
      // Zero edge and out-of-range counts near the top of the number range.
      set_grid(32'h7FFF_FFC0, 32'h7FFF_FFF0, 0, 0, 127);
      random_phase(50, 45);
      set_grid($urandom, $urandom_range(0, 32'h0FFF_FFFF), $urandom_range(300, 5000),
               8, 5);
      random_phase(60, 45);
      set_grid(0, 0, 256, 64, 64);
      random_phase(40, 50);

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("linked_cell_neighbour_grid_top regression: pass");
      else
         $display("linked_cell_neighbour_grid_top regression: fail");
      $finish;
   end

endmodule
